### hw/rtl/adc_pkg.sv
// ----------------------------------------------------------------------------
// adc_pkg
// Shared types and constants of the annotation deframer / classifier.
// ----------------------------------------------------------------------------
package adc_pkg;

    localparam int unsigned NAME_COUNT = 25;
    localparam int unsigned NAME_CHARS = 24;

    localparam logic [4:0] NO_MATCH = 5'd25;
    localparam logic [4:0] LEN_MAX  = 5'd31;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SUB = 8'h1A;

    // Command ops: which result sequence the back end plays out
    localparam logic [2:0] OP_D        = 3'd0;  // d
    localparam logic [2:0] OP_LF_D     = 3'd1;  // LF, d
    localparam logic [2:0] OP_LF_SUB   = 3'd2;  // LF, SUB
    localparam logic [2:0] OP_LF_SUB_D = 3'd3;  // LF, SUB, d
    localparam logic [2:0] OP_ANN      = 3'd4;  // annotation report

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [4:0] code;
    } adc_cmd_t;

    // Name strings, right-justified: first char sits in the highest used byte
    localparam logic [8*NAME_CHARS-1:0] NAME_TABLE [NAME_COUNT] = '{
        "source", "frame-end", "frames-invalid", "pre-commands", "commands",
        "post-commands", "pre-overload-choice", "overload-choice",
        "post-overload-choice", "pre-instance-choice", "instance-choice",
        "post-instance-choice", "pre-query", "query", "post-query",
        "pre-prompt-for-continue", "prompt-for-continue",
        "post-prompt-for-continue", "pre-prompt", "prompt", "post-prompt",
        "error-begin", "error", "quit", "exited"
    };

    localparam logic [4:0] NAME_LEN [NAME_COUNT] = '{
        5'd6, 5'd9, 5'd14, 5'd12, 5'd8, 5'd13, 5'd19, 5'd15, 5'd20, 5'd19,
        5'd15, 5'd20, 5'd9, 5'd5, 5'd10, 5'd23, 5'd19, 5'd24, 5'd10, 5'd6,
        5'd11, 5'd11, 5'd5, 5'd4, 5'd6
    };

    // Character at position pos of name idx; zero past the end of the name
    function automatic logic [7:0] name_char(input int unsigned idx,
                                             input logic [4:0] pos);
        int unsigned sh;
        logic [7:0]  ch;
        ch = 8'h00;
        sh = 0;
        if (pos < NAME_LEN[idx])
        begin
            sh = 32'(NAME_LEN[idx]) - 32'd1 - 32'(pos);
            ch = NAME_TABLE[idx][8*sh +: 8];
        end
        return ch;
    endfunction

endpackage

### hw/rtl/adc_front.sv
// ----------------------------------------------------------------------------
// adc_front
// Framer and name matcher: takes one byte per beat and issues one command
// per byte that produces results.
// ----------------------------------------------------------------------------
module adc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] byte_in
    input  logic              q_full,
    output logic              q_push,
    output adc_pkg::adc_cmd_t q_cmd
);
    import adc_pkg::*;

    localparam logic [2:0] ST_DATA       = 3'd0;
    localparam logic [2:0] ST_NEW_LINE   = 3'd1;
    localparam logic [2:0] ST_CONTROL_Z  = 3'd2;
    localparam logic [2:0] ST_ANNOTATION = 3'd3;
    localparam logic [2:0] ST_NL_DATA    = 3'd4;

    logic [2:0]            st_reg, st_next;
    logic [NAME_COUNT-1:0] mask_reg, mask_next;
    logic [4:0]            len_reg, len_next;

    logic                  accept;
    logic [7:0]            b;
    logic [2:0]            st;
    logic [NAME_COUNT-1:0] mismatch;
    logic [4:0]            ann_code;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign st       = (st_reg > ST_NL_DATA) ? ST_DATA : st_reg;

    always_comb
    begin
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            mismatch[i] = (len_reg < NAME_LEN[i]) && (name_char(i, len_reg) != b);
        end
    end

    // First name still consistent and fully covered by the name bytes
    always_comb
    begin
        ann_code = NO_MATCH;
        for (int i = NAME_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && (len_reg >= NAME_LEN[i]))
            begin
                ann_code = 5'(i);
            end
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        q_push     = 1'b0;
        q_cmd.op   = OP_D;
        q_cmd.data = b;
        q_cmd.code = 5'd0;
        if (accept && (b != CH_CR))
        begin
            st_next = st;
            if (b == CH_LF)
            begin
                unique case (st)
                    ST_NEW_LINE:
                    begin
                        q_push = 1'b1;
                    end
                    ST_CONTROL_Z:
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_LF_SUB;
                        st_next  = ST_DATA;
                    end
                    ST_ANNOTATION:
                    begin
                        q_push     = 1'b1;
                        q_cmd.op   = OP_ANN;
                        q_cmd.data = 8'h00;
                        q_cmd.code = ann_code;
                        mask_next  = '1;
                        len_next   = 5'd0;
                        st_next    = ST_NL_DATA;
                    end
                    default:
                    begin
                        st_next = ST_NEW_LINE;
                    end
                endcase
            end
            else if (b == CH_SUB)
            begin
                unique case (st)
                    ST_DATA:
                    begin
                        q_push = 1'b1;
                    end
                    ST_NEW_LINE, ST_NL_DATA:
                    begin
                        st_next = ST_CONTROL_Z;
                    end
                    ST_CONTROL_Z:
                    begin
                        st_next = ST_ANNOTATION;
                    end
                    default:
                    begin
                        mask_next = mask_reg & ~mismatch;
                        if (len_reg < LEN_MAX)
                        begin
                            len_next = len_reg + 5'd1;
                        end
                    end
                endcase
            end
            else
            begin
                unique case (st)
                    ST_NEW_LINE:
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_LF_D;
                        st_next  = ST_DATA;
                    end
                    ST_CONTROL_Z:
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_LF_SUB_D;
                        st_next  = ST_DATA;
                    end
                    ST_ANNOTATION:
                    begin
                        mask_next = mask_reg & ~mismatch;
                        if (len_reg < LEN_MAX)
                        begin
                            len_next = len_reg + 5'd1;
                        end
                    end
                    default:
                    begin
                        q_push  = 1'b1;
                        st_next = ST_DATA;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_DATA;
            mask_reg <= '1;
            len_reg  <= 5'd0;
        end
        else
        begin
            st_reg   <= st_next;
            mask_reg <= mask_next;
            len_reg  <= len_next;
        end
    end

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg <= ST_NL_DATA)
        else $error("framer state out of range");

endmodule

### hw/rtl/adc_fifo.sv
// ----------------------------------------------------------------------------
// adc_fifo
// Small command queue between the framer and the result sequencer.
// ----------------------------------------------------------------------------
module adc_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  adc_pkg::adc_cmd_t wr_cmd,
    input  logic              pop,
    output adc_pkg::adc_cmd_t rd_cmd,
    output logic              full,
    output logic              empty
);
    import adc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    adc_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command pushed into full queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

### hw/rtl/adc_back.sv
// ----------------------------------------------------------------------------
// adc_back
// Result sequencer: expands each command into one to three result beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module adc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  adc_pkg::adc_cmd_t q_cmd,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] byte_out, [12:8] annotation_code
    output logic              m_tlast,
    output logic              m_tuser    // [0] kind
);
    import adc_pkg::*;

    logic [1:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic [15:0] data_reg, data_next;
    logic        last_reg, last_next;
    logic        kind_reg, kind_next;

    logic        load;
    logic [1:0]  n_res;
    logic [7:0]  res_byte;

    assign load = !valid_reg || m_tready;

    always_comb
    begin
        unique case (q_cmd.op)
            OP_LF_D, OP_LF_SUB: n_res = 2'd2;
            OP_LF_SUB_D:        n_res = 2'd3;
            default:            n_res = 2'd1;
        endcase
    end

    always_comb
    begin
        res_byte = q_cmd.data;
        unique case (step_reg)
            2'd0:
            begin
                if (q_cmd.op == OP_LF_D || q_cmd.op == OP_LF_SUB || q_cmd.op == OP_LF_SUB_D)
                begin
                    res_byte = CH_LF;
                end
            end
            2'd1:
            begin
                if (q_cmd.op == OP_LF_SUB || q_cmd.op == OP_LF_SUB_D)
                begin
                    res_byte = CH_SUB;
                end
            end
            default:
            begin
                res_byte = q_cmd.data;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        q_pop      = 1'b0;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                kind_next = (q_cmd.op == OP_ANN);
                if (q_cmd.op == OP_ANN)
                begin
                    data_next = {3'b000, q_cmd.code, 8'h00};
                end
                else
                begin
                    data_next = {3'b000, 5'd0, res_byte};
                end
                last_next = (step_reg == n_res - 2'd1);
                if (step_reg == n_res - 2'd1)
                begin
                    q_pop     = 1'b1;
                    step_next = 2'd0;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        kind_reg <= kind_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;

    a_ann_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[7:0] == 8'h00))
        else $error("annotation beat not a lone, byte-free result");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != 2'd3)
        else $error("sequencer step out of range");

endmodule

### hw/rtl/annotation_deframer_classifier_unit.sv
// ----------------------------------------------------------------------------
// annotation_deframer_classifier_unit
// Path: each command is written into the queue, then into the registered output
// stage. Throughput: one byte per cycle unless the queue is full; the output port
// gives one result per cycle while the sink is ready, so bytes that break a marker
// (two or three results) drain through the queue.
// Reset (rst_n low, async): framer in data state, name flags all set, queue
// and output stage empty.
// ----------------------------------------------------------------------------
module annotation_deframer_classifier_unit
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] byte_out, [12:8] annotation_code
    output logic        m_tlast,
    output logic        m_tuser     // [0] kind
);
    import adc_pkg::*;

    adc_cmd_t push_cmd;
    adc_cmd_t head_cmd;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    adc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    adc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .full   (full),
        .empty  (empty)
    );

    adc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (head_cmd),
        .q_empty  (empty),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives annotation_deframer_classifier_unit with framed and unframed byte
// streams, random stalls on both sides, and checks every output beat against
// a behavioral deframer/classifier kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module testbench;

    import adc_pkg::*;

    typedef enum logic [2:0] {
        FS_DATA       = 3'd0,
        FS_NEW_LINE   = 3'd1,
        FS_CONTROL_Z  = 3'd2,
        FS_ANNOTATION = 3'd3,
        FS_NL_DATA    = 3'd4
    } frame_state_e;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_out;
        logic [4:0] code;
        logic       last;
    } deframed_beat_t;

    typedef struct {
        logic [7:0] data;
        bit         drain_first;
    } raw_byte_t;

    typedef logic [7:0] byte_q_t [$];

    string name_strings [NAME_COUNT] = '{
        "source", "frame-end", "frames-invalid", "pre-commands", "commands",
        "post-commands", "pre-overload-choice", "overload-choice",
        "post-overload-choice", "pre-instance-choice", "instance-choice",
        "post-instance-choice", "pre-query", "query", "post-query",
        "pre-prompt-for-continue", "prompt-for-continue",
        "post-prompt-for-continue", "pre-prompt", "prompt", "post-prompt",
        "error-begin", "error", "quit", "exited"
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] byte_in
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [7:0] byte_out, [12:8] annotation_code
    logic        m_tlast;
    logic        m_tuser;     // [0] kind

    // shadow state of the framer and name matcher
    frame_state_e           frm_state = FS_DATA;
    logic [NAME_COUNT-1:0]  name_flags = '1;
    logic [4:0]             name_used = 5'd0;

    raw_byte_t      raw_bytes_q [$];
    deframed_beat_t pending_beats_q [$];
    int             stim_count = 0;
    bit             drain_next = 1'b0;
    int             n_errors = 0;

    int         send_gap;
    bit         send_calm = 1'b0;
    logic       next_valid;
    logic [7:0] next_data;
    int         recv_stall;
    bit         recv_calm = 1'b0;

    annotation_deframer_classifier_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic deframed_beat_t data_beat(input logic [7:0] b);
        deframed_beat_t r;
        r = '0;
        r.byte_out = b;
        return r;
    endfunction

    function automatic void take_name_byte(input logic [7:0] b);
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            if (name_used < name_strings[i].len() && 8'(name_strings[i][name_used]) != b)
                name_flags[i] = 1'b0;
        end
        if (name_used != LEN_MAX)
            name_used++;
    endfunction

    // Advance the shadow framer by one byte and queue the beats it produces
    function automatic void deframe(input logic [7:0] b);
        deframed_beat_t outs [$];
        deframed_beat_t r;
        frame_state_e   st;
        st = frm_state;
        if (b == CH_CR)
            return;
        if (b == CH_LF)
        begin
            case (st)
                FS_NEW_LINE:
                    outs.push_back(data_beat(CH_LF));
                FS_CONTROL_Z:
                begin
                    outs.push_back(data_beat(CH_LF));
                    outs.push_back(data_beat(CH_SUB));
                    st = FS_DATA;
                end
                FS_ANNOTATION:
                begin
                    r = '0;
                    r.kind = 1'b1;
                    r.code = NO_MATCH;
                    for (int i = int'(NAME_COUNT) - 1; i >= 0; i--)
                    begin
                        if (name_flags[i] && name_used >= name_strings[i].len())
                            r.code = 5'(i);
                    end
                    outs.push_back(r);
                    name_flags = '1;
                    name_used = 5'd0;
                    st = FS_NL_DATA;
                end
                default:
                    st = FS_NEW_LINE;
            endcase
        end
        else if (b == CH_SUB)
        begin
            case (st)
                FS_DATA:
                    outs.push_back(data_beat(CH_SUB));
                FS_NEW_LINE, FS_NL_DATA:
                    st = FS_CONTROL_Z;
                FS_CONTROL_Z:
                    st = FS_ANNOTATION;
                default:
                    take_name_byte(b);
            endcase
        end
        else
        begin
            case (st)
                FS_NEW_LINE:
                begin
                    outs.push_back(data_beat(CH_LF));
                    outs.push_back(data_beat(b));
                    st = FS_DATA;
                end
                FS_CONTROL_Z:
                begin
                    outs.push_back(data_beat(CH_LF));
                    outs.push_back(data_beat(CH_SUB));
                    outs.push_back(data_beat(b));
                    st = FS_DATA;
                end
                FS_ANNOTATION:
                    take_name_byte(b);
                default:
                begin
                    outs.push_back(data_beat(b));
                    st = FS_DATA;
                end
            endcase
        end
        frm_state = st;
        if (outs.size() != 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            pending_beats_q.push_back(outs[i]);
    endfunction

    function automatic void push_raw(input logic [7:0] b);
        raw_byte_t item;
        item.data = b;
        item.drain_first = drain_next;
        drain_next = 1'b0;
        raw_bytes_q.push_back(item);
        if (b != CH_CR)
            stim_count++;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0, 1:    b = CH_LF;
            2, 3:    b = CH_SUB;
            4:       b = CH_CR;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // any byte that stays inside a name: no newline, a fair share of SUB
    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            b = CH_SUB;
        if (b == CH_LF)
            b = 8'h2D;
        return b;
    endfunction

    function automatic byte_q_t table_name(input int idx);
        byte_q_t q;
        for (int j = 0; j < name_strings[idx].len(); j++)
            q.push_back(8'(name_strings[idx][j]));
        return q;
    endfunction

    function automatic void push_annotation(input byte_q_t name_q);
        push_raw(CH_LF);
        push_raw(CH_SUB);
        push_raw(CH_SUB);
        foreach (name_q[i])
        begin
            if ($urandom_range(0, 9) == 0)
                push_raw(CH_CR);
            push_raw(name_q[i]);
        end
        push_raw(CH_LF);
    endfunction

    // Sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            next_valid = s_tvalid;
            next_data = s_tdata;
            if (s_tvalid && s_tready)
            begin
                deframe(s_tdata);
                next_valid = 1'b0;
                if ($urandom_range(0, 24) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 10);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (raw_bytes_q.size() != 0 &&
                         (!raw_bytes_q[0].drain_first || pending_beats_q.size() == 0))
                begin
                    next_valid = 1'b1;
                    next_data = raw_bytes_q[0].data;
                    raw_bytes_q.delete(0);
                end
            end
            s_tvalid <= next_valid;
            s_tdata <= next_data;
        end
    end

    // Receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        deframed_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid === 1'b1 && m_tready)
            begin
                if (pending_beats_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected beat, got kind=%0b data=%04h last=%0b",
                             $time, m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    want = pending_beats_q.pop_front();
                    if (m_tuser !== want.kind || m_tlast !== want.last ||
                        m_tdata !== {3'b000, want.code, want.byte_out})
                    begin
                        n_errors++;
                        $display("%0t: mismatch, expected kind=%0b data=%04h last=%0b, got kind=%0b data=%04h last=%0b",
                                 $time, want.kind, {3'b000, want.code, want.byte_out},
                                 want.last, m_tuser, m_tdata, m_tlast);
                    end
                end
                if ($urandom_range(0, 24) == 0)
                    recv_calm = !recv_calm;
                recv_stall = recv_calm ? 0 : $urandom_range(0, 10);
            end
            if (recv_stall > 0)
            begin
                m_tready <= 1'b0;
                recv_stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [7:0] opening [14] = '{8'h00, 8'hFF, CH_SUB, CH_LF, CH_LF, CH_CR, 8'h41,
                                     CH_LF, CH_SUB, CH_LF, CH_LF, CH_SUB, CH_CR, 8'h7F};
        byte_q_t    name_q;
        int         seq_no;
        int         idx;
        int         cut;

        // directed: every framer state, broken markers, CR, a known name and an empty one
        foreach (opening[i])
            push_raw(opening[i]);
        push_annotation(table_name(23));
        push_annotation(name_q);
        push_raw(8'h80);

        // long name: saturates the length count, still matches its table entry
        drain_next = 1'b1;
        name_q = table_name(17);
        repeat (10)
            name_q.push_back(name_byte());
        push_annotation(name_q);

        seq_no = 0;
        while (stim_count < 160)
        begin
            seq_no++;
            if (seq_no % 8 == 0)
                drain_next = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    idx = $urandom_range(0, NAME_COUNT - 1);
                    name_q = table_name(idx);
                    case ($urandom_range(0, 9))
                        6, 7:
                            repeat ($urandom_range(1, 6))
                                name_q.push_back(name_byte());
                        8:
                        begin
                            cut = $urandom_range(1, name_q.size() - 1);
                            repeat (cut)
                                void'(name_q.pop_back());
                        end
                        9:
                        begin
                            name_q = {};
                            repeat ($urandom_range(0, 8))
                                name_q.push_back(name_byte());
                        end
                        default:
                            ;
                    endcase
                    push_annotation(name_q);
                    if ($urandom_range(0, 1) == 0)
                        push_raw(noise_byte());
                end
                5, 6:
                begin
                    push_raw(CH_LF);
                    if ($urandom_range(0, 1) == 0)
                        push_raw(CH_SUB);
                    push_raw(noise_byte());
                end
                default:
                    repeat ($urandom_range(1, 6))
                        push_raw(noise_byte());
            endcase
        end

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        while (raw_bytes_q.size() != 0 || s_tvalid || pending_beats_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hw/rtl/adc_pkg.sv
hw/rtl/adc_front.sv
hw/rtl/adc_fifo.sv
hw/rtl/adc_back.sv
hw/rtl/annotation_deframer_classifier_unit.sv
tb/testbench.sv
